[src/battery_charge_level_monitor_macros.svh]
// Assertion macros shared by the verification checkers of the charge monitor.
// No dependencies; included by bclm_checker.sv.
`ifndef BATTERY_CHARGE_LEVEL_MONITOR_MACROS_SVH
`define BATTERY_CHARGE_LEVEL_MONITOR_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define BCLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define BCLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define BCLM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/bclm_pkg.sv]
// Types, constants and the cell voltage table of the battery charge monitor.
// No dependencies; used by every module of the block.
`default_nettype none

package bclm_pkg;

    // One input word: sample time and calibrated pin voltage.
    typedef struct packed {
        logic [31:0] time_ms;
        logic [11:0] pin_millivolts;
    } t_in_word;

    // One output word.
    typedef struct packed {
        logic [12:0] pack_millivolts;
        logic [12:0] filtered_millivolts;
        logic [6:0]  charge_percent;
    } t_out_word;

    // Configuration register indexes.
    localparam logic [1:0] REG_LED_DROP      = 2'd0;
    localparam logic [1:0] REG_READ_INTERVAL = 2'd1;
    localparam logic [1:0] REG_CELL_COUNT    = 2'd2;

    localparam logic [11:0] LED_DROP_RESET      = 12'd1700;
    localparam logic [15:0] READ_INTERVAL_RESET = 16'd1000;
    localparam logic [3:0]  CELL_COUNT_RESET    = 4'd1;

    // Fixed point: millivolts with 8 fraction bits.
    localparam int FRAC_BITS = 8;
    localparam int FILT_W    = 21;
    localparam int NUM_W     = 24;
    localparam int IDX_W     = 7;
    localparam int ROUND_W   = 5;
    localparam int Q_W       = 18;

    // Division by ten as a reciprocal multiply, exact for operands below 2^22.
    localparam int                RECIP_SHIFT = 24;
    localparam logic [FILT_W-1:0] RECIP_10    = 21'd1677722;

    localparam logic [FILT_W-1:0] CELL_OFFSET = 21'(100 * 256);
    localparam logic [FILT_W-1:0] FULL_CELL   = 21'(4200 * 256);
    localparam logic [FILT_W-1:0] EMPTY_CELL  = 21'(3200 * 256);

    // The divider retires four quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES         = NUM_W / DIV_BITS_PER_CYCLE;

    localparam int               TABLE_ENTRIES = 101;
    localparam logic [IDX_W-1:0] LAST_IDX      = 7'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] SEARCH_START  = 7'((TABLE_ENTRIES - 1) / 2);
    localparam logic [IDX_W-1:0] FULL_PERCENT  = 7'd100;
    localparam logic [IDX_W-1:0] EMPTY_PERCENT = 7'd0;

    localparam logic [12:0] CELL_TABLE_MV [0:TABLE_ENTRIES-1] = '{
        13'd3200,
        13'd3250, 13'd3300, 13'd3350, 13'd3400, 13'd3450, 13'd3500, 13'd3550, 13'd3600,
        13'd3650, 13'd3700, 13'd3703, 13'd3706, 13'd3710, 13'd3713, 13'd3716,
        13'd3719, 13'd3723, 13'd3726, 13'd3729, 13'd3732, 13'd3735, 13'd3739, 13'd3742,
        13'd3745, 13'd3748, 13'd3752, 13'd3755, 13'd3758, 13'd3761, 13'd3765,
        13'd3768, 13'd3771, 13'd3774, 13'd3777, 13'd3781, 13'd3784, 13'd3787, 13'd3790,
        13'd3794, 13'd3797, 13'd3800, 13'd3805, 13'd3811, 13'd3816, 13'd3821,
        13'd3826, 13'd3832, 13'd3837, 13'd3842, 13'd3847, 13'd3853, 13'd3858, 13'd3863,
        13'd3868, 13'd3874, 13'd3879, 13'd3884, 13'd3889, 13'd3895, 13'd3900,
        13'd3906, 13'd3911, 13'd3917, 13'd3922, 13'd3928, 13'd3933, 13'd3939, 13'd3944,
        13'd3950, 13'd3956, 13'd3961, 13'd3967, 13'd3972, 13'd3978, 13'd3983,
        13'd3989, 13'd3994, 13'd4000, 13'd4008, 13'd4015, 13'd4023, 13'd4031, 13'd4038,
        13'd4046, 13'd4054, 13'd4062, 13'd4069, 13'd4077, 13'd4085, 13'd4092,
        13'd4100, 13'd4111, 13'd4122, 13'd4133, 13'd4144, 13'd4156, 13'd4167, 13'd4178,
        13'd4189, 13'd4200
    };

    // Table read; indexes past the end never occur and read as zero.
    function automatic logic [12:0] table_mv(input logic [IDX_W-1:0] idx);
        logic [12:0] val;
        val = 13'd0;
        if (idx <= LAST_IDX) begin
            val = CELL_TABLE_MV[idx];
        end
        return val;
    endfunction

    // Controller to datapath commands.
    typedef struct packed {
        logic load_in;
        logic check;
        logic fdiff;
        logic fmul;
        logic fupd;
        logic dload;
        logic div_step;
        logic classify;
        logic search;
        logic load_out;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic due;
        logic full;
        logic empty;
        logic search_done;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

[src/battery_charge_level_monitor.sv]
// Top level of the battery charge monitor: configuration registers, controller
// and datapath. Depends on bclm_pkg, bclm_ctrl and bclm_dp.
`default_nettype none

// The monitor takes one input word (a millisecond timestamp and a calibrated
// pin voltage) at a time and answers each sample that is due with one output
// word: the pack voltage (pin plus LED drop), the filtered pack voltage and
// the per-cell charge in percent. A sample arriving sooner than the read
// interval after the last due sample (due time wrapping at 32 bits, compared
// unsigned) is dropped and produces no word. The filter moves one tenth of
// the way toward each new sample (the first nonzero sample seeds it), and the
// filtered voltage plus 100 mV is divided by the cell count (zero counts as
// one) before a halving search over a 101-entry cell voltage table yields the
// percentage. The input side is ready only while the controller is idle. A
// cell voltage at or beyond the table's ends skips the search; otherwise the
// search runs until its index settles (6 rounds for this table) and is
// capped at 32 rounds. The input side opens again in the cycle after the
// word is loaded. The divider retires four quotient bits per cycle, and the
// search reads the table once per cycle. The output register holds a
// finished word while the next sample is accepted and processed; processing
// stalls at its end only if that word has still not been taken.
// Configuration writes are always accepted and must be made while the block
// is idle.
module battery_charge_level_monitor (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  bclm_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output bclm_pkg::t_out_word  o_out_word,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [1:0]            i_cfg_index,
    input  wire [15:0]           i_cfg_data
);
    import bclm_pkg::*;

    logic [11:0] r_led_drop;
    logic [15:0] r_read_interval;
    logic [3:0]  r_cell_count;
    t_cmd        cmd;
    t_sts        sts;

    // The register file takes a configuration word in every cycle; an index
    // beyond the three registers is accepted and ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_drop      <= LED_DROP_RESET;
            r_read_interval <= READ_INTERVAL_RESET;
            r_cell_count    <= CELL_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LED_DROP:      r_led_drop      <= i_cfg_data[11:0];
                REG_READ_INTERVAL: r_read_interval <= i_cfg_data;
                REG_CELL_COUNT:    r_cell_count    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // The controller sequences the work of one sample through the datapath.
    bclm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the sampler state, the filter, the divider, the
    // table search and the output register.
    bclm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_word       (i_in_word),
        .i_led_drop      (r_led_drop),
        .i_read_interval (r_read_interval),
        .i_cell_count    (r_cell_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_word      (o_out_word)
    );

endmodule

`default_nettype wire

[src/bclm_ctrl.sv]
// Sequencing state machine of the charge monitor.
// Depends on bclm_pkg for the command and status structs.
`default_nettype none

module bclm_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  bclm_pkg::t_sts  i_sts,
    output bclm_pkg::t_cmd  o_cmd
);
    import bclm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_FDIFF  = 4'd2;
    localparam logic [3:0] ST_FMUL   = 4'd3;
    localparam logic [3:0] ST_FUPD   = 4'd4;
    localparam logic [3:0] ST_DLOAD  = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_CLASS  = 4'd7;
    localparam logic [3:0] ST_SEARCH = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.due ? ST_FDIFF : ST_IDLE;
            end
            ST_FDIFF: begin
                o_cmd.fdiff = 1'b1;
                n_state     = ST_FMUL;
            end
            ST_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = ST_FUPD;
            end
            ST_FUPD: begin
                o_cmd.fupd = 1'b1;
                n_state    = ST_DLOAD;
            end
            ST_DLOAD: begin
                o_cmd.dload = 1'b1;
                n_cnt       = 3'd0;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 3'd1;
                if (r_cnt == 3'(DIV_CYCLES - 1)) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                o_cmd.classify = 1'b1;
                n_state        = (i_sts.full || i_sts.empty) ? ST_OUT : ST_SEARCH;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[src/bclm_dp.sv]
// Datapath of the charge monitor: interval check, filter, divider, table search
// and output register. Depends on bclm_pkg.
`default_nettype none

module bclm_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bclm_pkg::t_cmd      i_cmd,
    output bclm_pkg::t_sts      o_sts,
    input  bclm_pkg::t_in_word  i_in_word,
    input  wire [11:0]          i_led_drop,
    input  wire [15:0]          i_read_interval,
    input  wire [3:0]           i_cell_count,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bclm_pkg::t_out_word o_out_word
);
    import bclm_pkg::*;

    logic [31:0]         r_time;
    logic [11:0]         r_pin;
    logic [31:0]         r_last;
    logic [12:0]         r_pack;
    logic [FILT_W-1:0]   r_filt;
    logic                r_neg;
    logic [FILT_W-1:0]   r_absdiff;
    logic [Q_W-1:0]      r_q;
    logic [NUM_W-1:0]    r_num;
    logic [3:0]          r_rem;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_prev;
    logic [ROUND_W-1:0]  r_round;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [31:0]         due_time;
    logic [FILT_W-1:0]   big;
    logic [FILT_W:0]     diff;
    logic [2*FILT_W-1:0] prod;
    logic [3:0]          divisor;
    logic [NUM_W-1:0]    n_num;
    logic [3:0]          n_rem;
    logic [4:0]          trial;
    logic [IDX_W-1:0]    mag;
    logic [IDX_W-1:0]    half;
    logic [IDX_W:0]      up_sum;
    logic                go_up;
    logic [IDX_W-1:0]    n_idx;

    assign due_time = r_last + 32'(i_read_interval);
    assign big      = {r_pack, 8'd0};
    assign diff     = {1'b0, big} - {1'b0, r_filt};
    assign prod     = (2*FILT_W)'(r_absdiff) * (2*FILT_W)'(RECIP_10);
    assign divisor  = (i_cell_count == 4'd0) ? 4'd1 : i_cell_count;

    // Restoring division, several quotient bits per cycle; the remainder stays
    // below the four-bit divisor, so each step is a narrow compare and subtract.
    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        trial = 5'd0;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            trial = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                n_rem    = 4'(trial - {1'b0, divisor});
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[3:0];
            end
        end
    end

    // One round of the halving search over the table.
    always_comb begin
        mag    = (r_idx >= r_prev) ? (r_idx - r_prev) : (r_prev - r_idx);
        half   = mag >> 1;
        go_up  = r_num >= NUM_W'({table_mv(r_idx), 8'd0});
        up_sum = {1'b0, r_idx} + {1'b0, half};
        if (go_up) begin
            n_idx = (up_sum > {1'b0, LAST_IDX}) ? LAST_IDX : up_sum[IDX_W-1:0];
        end else begin
            n_idx = (r_idx < half) ? EMPTY_PERCENT : (r_idx - half);
        end
    end

    assign o_sts.due         = !(r_time < due_time);
    assign o_sts.full        = r_num >= NUM_W'(FULL_CELL);
    assign o_sts.empty       = r_num <= NUM_W'(EMPTY_CELL);
    assign o_sts.search_done = (n_idx == r_idx) || (r_round == '1);
    assign o_sts.out_busy    = r_out_valid && !i_out_ready;

    // Sampler state and output valid need reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 32'd0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.check && o_sts.due) begin
                r_last <= r_time;
            end
            if (i_cmd.fupd) begin
                if (r_filt == '0) begin
                    r_filt <= big;
                end else if (r_neg) begin
                    r_filt <= r_filt - FILT_W'(r_q);
                end else begin
                    r_filt <= r_filt + FILT_W'(r_q);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_time <= i_in_word.time_ms;
            r_pin  <= i_in_word.pin_millivolts;
        end
        if (i_cmd.check) begin
            r_pack <= 13'(r_pin) + 13'(i_led_drop);
        end
        if (i_cmd.fdiff) begin
            r_neg     <= diff[FILT_W];
            r_absdiff <= diff[FILT_W] ? FILT_W'(-diff) : diff[FILT_W-1:0];
        end
        if (i_cmd.fmul) begin
            r_q <= prod[RECIP_SHIFT +: Q_W];
        end
        if (i_cmd.dload) begin
            r_num <= NUM_W'(r_filt) + NUM_W'(CELL_OFFSET);
            r_rem <= 4'd0;
        end
        if (i_cmd.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
        if (i_cmd.classify) begin
            r_prev  <= EMPTY_PERCENT;
            r_round <= '0;
            if (o_sts.full) begin
                r_idx <= FULL_PERCENT;
            end else if (o_sts.empty) begin
                r_idx <= EMPTY_PERCENT;
            end else begin
                r_idx <= SEARCH_START;
            end
        end
        if (i_cmd.search) begin
            r_prev  <= r_idx;
            r_idx   <= n_idx;
            r_round <= r_round + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_word.pack_millivolts     <= r_pack;
            r_out_word.filtered_millivolts <= r_filt[FILT_W-1:FRAC_BITS];
            r_out_word.charge_percent      <= r_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[src/bclm_checker.sv]
// Port-level checker of the charge monitor and its bind to the top level.
// Depends on bclm_pkg and battery_charge_level_monitor_macros.svh.
`default_nettype none
`include "battery_charge_level_monitor_macros.svh"

module bclm_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  o_in_ready,
    input  bclm_pkg::t_in_word   i_in_word,
    input  wire                  o_out_valid,
    input  wire                  i_out_ready,
    input  bclm_pkg::t_out_word  o_out_word
);
    import bclm_pkg::*;

    // A percentage never exceeds full charge.
    `BCLM_ASSERT_NOW(a_charge_range, i_clk, i_rst_n, o_out_valid, o_out_word.charge_percent <= FULL_PERCENT, "charge above full")

    // One sample at a time: after an accepted word the input side closes.
    `BCLM_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input accepted twice in a row")

    // An offered input word waits unchanged until the block takes it.
    `BCLM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_word), "waiting input changed")

    // A result word waiting for the consumer holds still.
    `BCLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "stalled result changed")

    // Reset leaves no stale result behind.
    `BCLM_ASSERT_ALWAYS_NEXT(a_reset_clears, i_clk, !i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind battery_charge_level_monitor bclm_checker u_bclm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for battery_charge_level_monitor: sample timing, filter and charge.
// Depends on bclm_pkg for the word types and register indexes, and on the RTL under src.

module testbench;

    import bclm_pkg::*;

    // Run limits. The slowest legal run stays far below the clock limit. It assumes
    // about 650 samples, each with its busy time plus sender gaps and
    // receiver stalls, plus settle time between the register phases.
    localparam int CLOCK_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PER_SET = 100;

    // Cell voltage table in mV, the curve that the charge search walks.
    localparam int unsigned CELL_MV_CURVE [0:100] = '{
        3200,
        3250, 3300, 3350, 3400, 3450, 3500, 3550, 3600, 3650, 3700, 3703, 3706, 3710, 3713, 3716,
        3719, 3723, 3726, 3729, 3732, 3735, 3739, 3742, 3745, 3748, 3752, 3755, 3758, 3761, 3765,
        3768, 3771, 3774, 3777, 3781, 3784, 3787, 3790, 3794, 3797, 3800, 3805, 3811, 3816, 3821,
        3826, 3832, 3837, 3842, 3847, 3853, 3858, 3863, 3868, 3874, 3879, 3884, 3889, 3895, 3900,
        3906, 3911, 3917, 3922, 3928, 3933, 3939, 3944, 3950, 3956, 3961, 3967, 3972, 3978, 3983,
        3989, 3994, 4000, 4008, 4015, 4023, 4031, 4038, 4046, 4054, 4062, 4069, 4077, 4085, 4092,
        4100, 4111, 4122, 4133, 4144, 4156, 4167, 4178, 4189, 4200
    };

    // Every input of the block starts at a known value.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_word   = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic        o_cfg_ready;

    battery_charge_level_monitor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow registers and state of the monitor. Configuration changes only
    // while the block is idle, so the shadow copy never races a sample.
    bit [11:0] led_drop_mv   = LED_DROP_RESET;
    bit [15:0] interval_ms   = READ_INTERVAL_RESET;
    bit [3:0]  cells_cfg     = CELL_COUNT_RESET;
    bit [31:0] last_time     = '0;
    bit [31:0] filt_q8       = '0;

    // Words that the block still owes, oldest first, and samples waiting to be sent.
    t_out_word expected_words [$];
    t_in_word  pending_samples [$];

    // Time of the last sample that the stimulus expects to be taken; used only
    // to aim new timestamps around the next due time.
    bit [31:0] aim_last = '0;

    int send_idle_pct = 24;
    int recv_idle_pct = 60;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int samples_taken = 0;
    int samples_due   = 0;
    int samples_early = 0;
    int words_checked = 0;
    int cfg_writes    = 0;
    int failures      = 0;
    int cycle_count   = 0;

    // Halving search over the cell curve. The cell voltage carries 8 fraction
    // bits; the ends of the curve are decided before the search starts.
    function automatic int unsigned percent_of_cell(input int unsigned cell_q8);
        int idx;
        int prev;
        int step;
        int half;
        int rnd;
        if (cell_q8 >= 4200 * 256) begin
            return 100;
        end
        if (cell_q8 <= 3200 * 256) begin
            return 0;
        end
        idx  = 50;
        prev = 0;
        for (rnd = 0; rnd < 32; rnd++) begin
            step = idx - prev;
            half = (step < 0 ? -step : step) / 2;
            prev = idx;
            if (cell_q8 >= CELL_MV_CURVE[idx] * 256) begin
                idx = idx + half;
            end else begin
                idx = idx - half;
            end
            if (idx < 0) begin
                idx = 0;
            end
            if (idx > 100) begin
                idx = 100;
            end
            if (prev == idx) begin
                break;
            end
        end
        return idx;
    endfunction

    // Runs one sample through the shadow monitor. Returns 1 and the word the
    // block must produce when the sample is due, 0 when it is dropped.
    function automatic bit sample_charge(input t_in_word w, output t_out_word res);
        bit [31:0]   due;
        int unsigned pack;
        int unsigned pack_q8;
        int unsigned cells;
        int unsigned cell_q8;
        int          diff;
        res = '0;
        // The due time wraps at 32 bits, and the comparison is unsigned.
        due = last_time + 32'(interval_ms);
        if (w.time_ms < due) begin
            return 1'b0;
        end
        last_time = w.time_ms;
        pack      = w.pin_millivolts + led_drop_mv;
        pack_q8   = pack << 8;
        // A zero filter means unseeded; a zero pack voltage leaves it that way.
        if (filt_q8 == 0) begin
            filt_q8 = pack_q8;
        end else begin
            // Signed division truncates toward zero, also when the filter falls.
            diff    = int'(pack_q8) - int'(filt_q8);
            filt_q8 = 32'(int'(filt_q8) + diff / 10);
        end
        filt_q8 &= 32'h001F_FFFF;
        cells   = (cells_cfg == 0) ? 1 : cells_cfg;
        cell_q8 = (filt_q8 + 100 * 256) / cells;
        res.pack_millivolts     = pack[12:0];
        res.filtered_millivolts = filt_q8[20:8];
        res.charge_percent      = 7'(percent_of_cell(cell_q8));
        return 1'b1;
    endfunction

    // Sample driver. It predicts each word at the edge where the block takes
    // it, then offers the next pending sample unless it decides to idle.
    always @(posedge i_clk) begin : sample_driver
        t_in_word  nxt_word;
        logic      nxt_valid;
        t_out_word owed;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_word  = i_in_word;
            if (i_in_valid && o_in_ready) begin
                samples_taken++;
                if (sample_charge(i_in_word, owed)) begin
                    expected_words.push_back(owed);
                    samples_due++;
                end else begin
                    samples_early++;
                end
                nxt_valid = 1'b0;
            end
            // A held word stays on the bus; a new one only follows an empty slot.
            if (!nxt_valid && pending_samples.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                nxt_word  = pending_samples.pop_front();
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
            i_in_word  <= nxt_word;
        end
    end

    // Result monitor. Each taken word is compared with the oldest owed word,
    // field by field. The receiver idles at random, and on request it holds
    // off for a long stretch so that the block backs up into its input.
    always @(posedge i_clk) begin : word_monitor
        t_out_word want;
        logic      nxt_ready;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %h", o_out_word);
                    failures++;
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (want.pack_millivolts !== o_out_word.pack_millivolts) begin
                        $error("pack_millivolts: expected %0d, actual %0d",
                               want.pack_millivolts, o_out_word.pack_millivolts);
                        failures++;
                    end
                    if (want.filtered_millivolts !== o_out_word.filtered_millivolts) begin
                        $error("filtered_millivolts: expected %0d, actual %0d",
                               want.filtered_millivolts, o_out_word.filtered_millivolts);
                        failures++;
                    end
                    if (want.charge_percent !== o_out_word.charge_percent) begin
                        $error("charge_percent: expected %0d, actual %0d",
                               want.charge_percent, o_out_word.charge_percent);
                        failures++;
                    end
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
            i_out_ready <= nxt_ready;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Writes one register and mirrors it into the shadow copy at the edge
    // where the block takes it.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_LED_DROP:      led_drop_mv = data[11:0];
            REG_READ_INTERVAL: interval_ms = data;
            REG_CELL_COUNT:    cells_cfg   = data[3:0];
            default:           ;
        endcase
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Queues one sample and tracks which timestamps the block should take.
    task automatic queue_sample(input bit [31:0] stamp, input int unsigned pin);
        t_in_word w;
        w.time_ms        = stamp;
        w.pin_millivolts = pin[11:0];
        pending_samples.push_back(w);
        if (stamp >= aim_last + 32'(interval_ms)) begin
            aim_last = stamp;
        end
    endtask

    // Sender pause: nothing new goes out until every owed word has come back.
    // A dropped sample owes nothing, so the block gets some settle cycles on top.
    task automatic drain_all();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || i_in_valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random sample. Most land at or past the due time; some come early,
    // some jump to an arbitrary time, some sit just below the 32-bit wrap.
    // Pin voltages are mostly aimed so that the cell voltage falls on the curve.
    task automatic queue_random_sample();
        bit [31:0]   stamp;
        int unsigned pick;
        int unsigned cells;
        int unsigned target;
        int unsigned pin;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            stamp = aim_last + interval_ms + $urandom_range(0, 2 * interval_ms + 20);
        end else if (pick < 88) begin
            stamp = aim_last + $urandom_range(0, (interval_ms == 0) ? 0 : interval_ms - 1);
        end else if (pick < 95) begin
            stamp = $urandom;
        end else begin
            stamp = 32'hFFFF_FFFF - $urandom_range(0, interval_ms);
        end
        cells = (cells_cfg == 0) ? 1 : cells_cfg;
        pick  = $urandom_range(0, 99);
        if (pick < 55) begin
            target = cells * $urandom_range(3150, 4250) - 100;
            pin    = (target > led_drop_mv) ? target - led_drop_mv : 0;
            if (pin > 3300) begin
                pin = 3300;
            end
        end else if (pick < 60) begin
            pin = 0;
        end else if (pick < 65) begin
            pin = 3300;
        end else begin
            pin = $urandom_range(0, 3300);
        end
        queue_sample(stamp, pin);
    endtask

    // New register settings, with the ends of each range picked often.
    task automatic write_random_settings(input bit shortest_interval);
        int unsigned led;
        int unsigned gap;
        int unsigned cells;
        case ($urandom_range(0, 4))
            0:       led = 0;
            1:       led = 3000;
            default: led = $urandom_range(0, 3000);
        endcase
        if (shortest_interval) begin
            gap = 1;
        end else begin
            case ($urandom_range(0, 4))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 65535);
                default: gap = $urandom_range(1, 200);
            endcase
        end
        cells = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 8);
        write_reg(REG_LED_DROP, 16'(led));
        write_reg(REG_READ_INTERVAL, 16'(gap));
        write_reg(REG_CELL_COUNT, 16'(cells));
    endtask

    initial begin : stimulus
        int phase;
        int part;
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset interval and cell count, no LED drop. A zero pack voltage must
        // leave the filter unseeded, and the first nonzero sample seeds it.
        write_reg(REG_LED_DROP, 16'd0);
        queue_sample(32'd0, 1500);
        queue_sample(32'd999, 3300);
        queue_sample(32'd1000, 0);
        queue_sample(32'd2000, 0);
        queue_sample(32'd3000, 3300);
        queue_sample(32'd4000, 2048);
        drain_all();

        // Largest LED drop, zero interval and zero cell count. Equal times are
        // due, an earlier one is not, and the filter climbs to a full cell.
        write_reg(REG_LED_DROP, 16'd3000);
        write_reg(REG_READ_INTERVAL, 16'd0);
        write_reg(REG_CELL_COUNT, 16'd0);
        for (n = 0; n < 5; n++) begin
            queue_sample(32'd4000, 3300);
        end
        queue_sample(32'd3999, 1);
        queue_sample(32'd4001, 0);
        drain_all();

        // Longest interval and most cells. The due time wraps past 2^32, so a
        // small time is early while the largest time is already due.
        write_reg(REG_LED_DROP, 16'd1700);
        write_reg(REG_READ_INTERVAL, 16'd65535);
        write_reg(REG_CELL_COUNT, 16'd8);
        queue_sample(32'hFFFF_FFF0, 1234);
        queue_sample(32'd5, 2222);
        queue_sample(32'hFFFF_FFFF, 3300);
        queue_sample(32'd65533, 0);
        queue_sample(32'd65534, 2730);

        // Random part in three idling regimes, two register settings each.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (part = 0; part < 2; part++) begin
                drain_all();
                write_random_settings(phase == 0 && part == 0);
                // With no idling at all, the receiver stops for a long stretch
                // while the sender keeps offering samples.
                if (phase == 2 && part == 0) begin
                    hold_requests++;
                end
                for (n = 0; n < RANDOM_PER_SET; n++) begin
                    queue_random_sample();
                end
            end
        end
        drain_all();

        $display("Covered %0d samples (%0d due, %0d dropped) across %0d register writes.",
                 samples_taken, samples_due, samples_early, cfg_writes);
        $display("Checked %0d result words, with random stalls and a %0d-cycle output hold.",
                 words_checked, HOLD_CYCLES);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
